>>> hdl/first_fit_free_space_map_assert.svh
// Assertion macros used by the free-space map top level.
`ifndef FIRST_FIT_FREE_SPACE_MAP_ASSERT_SVH
`define FIRST_FIT_FREE_SPACE_MAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ffsm_pkg.sv
// Types and constants of the first-fit free-space map.
`default_nettype none
package ffsm_pkg;
	localparam int ENTRIES_DEF = 64;
	localparam int PAGE_W      = 20;
	localparam int BYTES_W     = 13;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int SEG_CELLS   = 16;

	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PAGE_W-1:0]  page_number;
		logic [BYTES_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   found_page;
	} rsp_t;

	// Search carry handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] page;
	} carry_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;
endpackage
`default_nettype wire

>>> hdl/ffsm_cell.sv
// One table entry: stores page and free bytes, matches and passes the search carry.
`default_nettype none
module ffsm_cell import ffsm_pkg::*; (
	input  logic   clk,
	input  req_t   req,
	input  logic   active,
	input  logic   upd_we,
	input  logic   app_we,
	input  carry_t carry_in,
	output carry_t carry_out
);
	logic [PAGE_W-1:0]  page_q;
	logic [BYTES_W-1:0] free_q;
	logic               hit;

	always_comb begin
		hit = 1'b0;
		if (active) begin
			unique case (req.kind)
				KIND_UPDATE: hit = (page_q == req.page_number);
				KIND_FIND:   hit = (free_q >= req.byte_count);
				default:     hit = 1'b0;
			endcase
		end
		carry_out.found = carry_in.found | hit;
		carry_out.page  = (hit && !carry_in.found) ? page_q : carry_in.page;
	end

	// Append takes a fresh slot; an update rewrites the free count in place.
	always_ff @(posedge clk) begin
		if (app_we) begin
			page_q <= req.page_number;
			free_q <= req.byte_count;
		end else if (upd_we && hit) begin
			free_q <= req.byte_count;
		end
	end
endmodule
`default_nettype wire

>>> hdl/ffsm_row.sv
// Chain of entry cells, cut by a carry register every SEG_CELLS cells.
`default_nettype none
module ffsm_row import ffsm_pkg::*; #(
	parameter  int ENTRIES = ENTRIES_DEF,
	localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  logic             clk,
	input  req_t             req,
	input  logic [CNT_W-1:0] count,
	input  logic             upd_we,
	input  logic             app_we,
	output carry_t           carry_out
);
	carry_t cin  [ENTRIES];
	carry_t cout [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cin[i] = '0;
		end else if (i % SEG_CELLS == 0) begin : g_brk
			carry_t brk_q;
			always_ff @(posedge clk) begin
				brk_q <= cout[i-1];
			end
			assign cin[i] = brk_q;
		end else begin : g_link
			assign cin[i] = cout[i-1];
		end

		ffsm_cell u_cell (
			.clk       (clk),
			.req       (req),
			.active    (count > CNT_W'(i)),
			.upd_we    (upd_we),
			.app_we    (app_we && (count == CNT_W'(i))),
			.carry_in  (cin[i]),
			.carry_out (cout[i])
		);
	end

	assign carry_out = cout[ENTRIES-1];
endmodule
`default_nettype wire

>>> hdl/first_fit_free_space_map.sv
// Top level of the first-fit free-space map: request control and result register.
`default_nettype none
`include "first_fit_free_space_map_assert.svh"
//
// Usage:
//   A request (kind, page_number, byte_count) is taken at a rising edge with
//   start high and busy low. Update rewrites the free count of a listed page
//   or appends a new entry (status full when the table is at capacity). Find
//   returns the first entry in table order with enough free bytes, or status
//   not-found. Clear empties the table; kind 3 does nothing and answers ok.
//   Each request yields one response on rsp, qualified by done for exactly
//   one cycle. The receiver cannot stall, so rsp is never held back.
// Timing:
//   The entries form a row of cells; the search carry runs down the row and
//   is registered every SEG_CELLS cells, so it crosses one segment a cycle.
//   busy stays high while the carry crosses all NSEG = ceil(ENTRIES / SEG_CELLS)
//   segments after the accepting edge; done rises in the same cycle busy drops.
//   A new request can be taken as soon as busy drops, while done is high.
// Reset:
//   arst_n clears the entry count and control; stored entries are left as
//   they are and are never read until written again.
//
module first_fit_free_space_map import ffsm_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);
	localparam int NSEG  = (ENTRIES + SEG_CELLS - 1) / SEG_CELLS;
	localparam int SCW   = (NSEG > 1) ? $clog2(NSEG) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	state_t           state_q, state_d;
	logic [SCW-1:0]   seg_q;
	logic [CNT_W-1:0] count_q;
	req_t             req_q;
	logic             done_q;
	rsp_t             rsp_q, rsp_d;
	carry_t           fin;
	logic             accept, last_scan, full, upd_we, app_we;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_SCAN);
	assign full   = (count_q == CNT_W'(ENTRIES));

	// Row of entry cells; the request is held in req_q for the whole scan.
	ffsm_row #(.ENTRIES(ENTRIES)) u_row (
		.clk       (clk),
		.req       (req_q),
		.count     (count_q),
		.upd_we    (upd_we),
		.app_we    (app_we),
		.carry_out (fin)
	);

	// Sequence the scan and decide the outcome in its last cycle.
	always_comb begin
		state_d   = state_q;
		last_scan = 1'b0;
		upd_we    = 1'b0;
		app_we    = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (seg_q == SCW'(NSEG - 1)) begin
					last_scan = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		unique case (req_q.kind)
			KIND_UPDATE: begin
				upd_we = last_scan && fin.found;
				app_we = last_scan && !fin.found && !full;
				rsp_d.status = (!fin.found && full) ? STAT_FULL : STAT_OK;
			end
			KIND_FIND: begin
				rsp_d.status     = fin.found ? STAT_OK : STAT_NOT_FOUND;
				rsp_d.found_page = fin.found ? fin.page : '0;
			end
			default: begin
				rsp_d.status = STAT_OK;
			end
		endcase
	end

	// Hold state, segment counter, done strobe and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last_scan;
			if (accept || last_scan) begin
				seg_q <= '0;
			end else if (busy) begin
				seg_q <= seg_q + SCW'(1);
			end
			if (last_scan) begin
				if (app_we) begin
					count_q <= count_q + CNT_W'(1);
				end else if (req_q.kind == KIND_CLEAR) begin
					count_q <= '0;
				end
			end
		end
	end

	// Capture the request and the response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (last_scan) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`FFSM_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
	`FFSM_ASSERT_NEXT(a_scan_done, last_scan, done && !busy, "scan end without response")
	`FFSM_ASSERT_NOW(a_done_src, done, $past(last_scan), "response without a finished scan")
	`FFSM_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(ENTRIES), "entry count overflow")
	`FFSM_ASSERT_NOW(a_full_cap, done && rsp.status == STAT_FULL, full, "full status below capacity")
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the first-fit free-space map: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import ffsm_pkg::*;

	// The package names no code for the unused request kind. The block ignores it.
	localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;
	// Number of cell segments the search crosses. Use it as the drain margin.
	localparam int SCAN_CYCLES = (ENTRIES_DEF + SEG_CELLS - 1) / SEG_CELLS;
	localparam int RANDOM_REQUESTS = 1500;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	first_fit_free_space_map u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Shadow copy of the free-space table, kept in step with every accepted request.
	logic [PAGE_W-1:0]  shadow_page [ENTRIES_DEF];
	logic [BYTES_W-1:0] shadow_free [ENTRIES_DEF];
	int                 shadow_count;

	// Answers still owed by the block, oldest first.
	rsp_t pending_answers [$];

	int mismatches;
	int answers_seen;
	int n_update, n_append, n_full, n_find, n_hit, n_miss, n_clear, n_idle_kind;
	bit no_idle;

	// One row of the directed table. Rows with typed set carry an answer written by
	// hand. All other rows take their answer from the shadow table.
	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	plan_row_t plan [$];

	// Work out the answer to one request and apply its effect to the shadow table.
	function automatic rsp_t map_answer(input req_t r);
		rsp_t a;
		bit   hit;
		a.status = STAT_OK;
		a.found_page = '0;
		hit = 1'b0;
		case (r.kind)
			KIND_UPDATE: begin
				n_update++;
				// Rewrite a listed page in place, else append at the tail.
				for (int i = 0; i < shadow_count && !hit; i++) begin
					if (shadow_page[i] == r.page_number) begin
						shadow_free[i] = r.byte_count;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (shadow_count >= ENTRIES_DEF) begin
						a.status = STAT_FULL;
						n_full++;
					end else begin
						shadow_page[shadow_count] = r.page_number;
						shadow_free[shadow_count] = r.byte_count;
						shadow_count++;
						n_append++;
					end
				end
			end
			KIND_FIND: begin
				n_find++;
				// Take the first entry in table order with enough room.
				a.status = STAT_NOT_FOUND;
				for (int i = 0; i < shadow_count && !hit; i++) begin
					if (shadow_free[i] >= r.byte_count) begin
						a.status = STAT_OK;
						a.found_page = shadow_page[i];
						hit = 1'b1;
					end
				end
				if (hit)
					n_hit++;
				else
					n_miss++;
			end
			KIND_CLEAR: begin
				n_clear++;
				shadow_count = 0;
			end
			default: n_idle_kind++;
		endcase
		return a;
	endfunction

	// Present one request, hold it until the block takes it, then record what it owes.
	// Leave start high when the next request follows at once, so that start gets
	// only one assignment per edge.
	task automatic issue(input req_t r, input bit typed, input rsp_t want);
		rsp_t model;
		int   gap;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		model = map_answer(r);
		pending_answers.push_back(typed ? want : model);
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic plan_row(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] page,
			input logic [BYTES_W-1:0] bytes, input bit typed,
			input logic [STATUS_W-1:0] st, input logic [PAGE_W-1:0] fp);
		plan_row_t row;
		row.r.kind = kind;
		row.r.page_number = page;
		row.r.byte_count = bytes;
		row.typed = typed;
		row.want.status = st;
		row.want.found_page = fp;
		plan.push_back(row);
	endtask

	// Free-byte count for an update. Weight it toward the edges of the page size,
	// and let some counts run past the page size up to the field's top.
	function automatic logic [BYTES_W-1:0] draw_bytes();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) return '0;
		if (roll < 20) return 13'd4096;
		if (roll < 25) return '1;
		if (roll < 35) return BYTES_W'($urandom);
		return BYTES_W'($urandom_range(0, 4096));
	endfunction

	// Required bytes for a find. Often aim at a listed count, or one above it,
	// to work the at-least boundary.
	function automatic logic [BYTES_W-1:0] draw_need();
		logic [BYTES_W-1:0] v;
		if (shadow_count > 0 && $urandom_range(0, 99) < 35) begin
			v = shadow_free[$urandom_range(0, shadow_count - 1)];
			if ($urandom_range(0, 1) && v != '1)
				v = v + 1'b1;
			return v;
		end
		return draw_bytes();
	endfunction

	// One run of random traffic over a pool of pages. Small pools keep hitting listed
	// pages. Large pools push the table to capacity.
	task automatic random_episode(inout int counted);
		int                len, pool, roll;
		logic [PAGE_W-1:0] base, stride;
		req_t              r;
		rsp_t              none;
		none = '0;
		len = $urandom_range(10, 90);
		case ($urandom_range(0, 3))
			0: pool = 6;
			1: pool = 30;
			2: pool = 64;
			default: pool = 120;
		endcase
		base = PAGE_W'($urandom);
		stride = PAGE_W'($urandom_range(1, 4096)) | 20'd1;
		// Run about a quarter of the episodes back to back with no gaps.
		no_idle = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1)) begin
			r = '0;
			r.kind = KIND_CLEAR;
			issue(r, 1'b0, none);
			counted++;
		end
		for (int n = 0; n < len; n++) begin
			roll = $urandom_range(0, 99);
			// Fill the fields with noise first. A find or a clear must ignore it.
			r.page_number = PAGE_W'($urandom);
			r.byte_count = BYTES_W'($urandom);
			if (roll < 55) begin
				r.kind = KIND_UPDATE;
				if ($urandom_range(0, 9) != 0)
					r.page_number = PAGE_W'(base + stride * $urandom_range(0, pool - 1));
				r.byte_count = draw_bytes();
			end else if (roll < 93) begin
				r.kind = KIND_FIND;
				r.byte_count = draw_need();
			end else if (roll < 96) begin
				r.kind = KIND_CLEAR;
			end else begin
				r.kind = KIND_IDLE;
			end
			issue(r, 1'b0, none);
			if (r.kind != KIND_IDLE)
				counted++;
		end
	endtask

	// Check each answer as it comes. The block cannot be stalled, so sample done at
	// every edge.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t: expected no answer, got status %0d page %h",
					$time, rsp.status, rsp.found_page);
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, rsp.status);
				end
				if (rsp.found_page !== want.found_page) begin
					mismatches++;
					$display("%0t: found_page expected %h, got %h",
						$time, want.found_page, rsp.found_page);
				end
			end
		end
	end

	initial begin
		int   counted;
		rsp_t none;
		req_t r;
		none = '0;
		counted = 0;
		mismatches = 0;
		answers_seen = 0;
		shadow_count = 0;
		no_idle = 1'b0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. It covers the empty table, the unused kind, extreme pages and
		// counts, counts above the page size, update in place and clear with noisy fields.
		plan_row(KIND_FIND,   20'h00000, 13'd0,    1'b1, STAT_NOT_FOUND, 20'h0);
		plan_row(KIND_CLEAR,  20'h00000, 13'd0,    1'b1, STAT_OK,        20'h0);
		plan_row(KIND_IDLE,   20'hFFFFF, 13'h1FFF, 1'b1, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'hFFFFF, 13'h1FFF, 1'b1, STAT_NOT_FOUND, 20'h0);
		plan_row(KIND_UPDATE, 20'h00000, 13'd0,    1'b1, STAT_OK,        20'h0);
		plan_row(KIND_UPDATE, 20'hFFFFF, 13'h1FFF, 1'b1, STAT_OK,        20'h0);
		plan_row(KIND_UPDATE, 20'h12345, 13'd4096, 1'b1, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'h00000, 13'd0,    1'b1, STAT_OK,        20'h00000);
		plan_row(KIND_FIND,   20'h00000, 13'h1FFF, 1'b1, STAT_OK,        20'hFFFFF);
		plan_row(KIND_FIND,   20'h00000, 13'd4097, 1'b0, STAT_OK,        20'h0);
		plan_row(KIND_UPDATE, 20'h00000, 13'd5000, 1'b0, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'hABCDE, 13'd4097, 1'b0, STAT_OK,        20'h0);
		plan_row(KIND_UPDATE, 20'hFFFFF, 13'd0,    1'b0, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'h55555, 13'd5001, 1'b0, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'h00000, 13'd4096, 1'b0, STAT_OK,        20'h0);
		plan_row(KIND_IDLE,   20'h5A5A5, 13'h0AAA, 1'b1, STAT_OK,        20'h0);
		plan_row(KIND_CLEAR,  20'hFFFFF, 13'h1FFF, 1'b1, STAT_OK,        20'h0);
		plan_row(KIND_FIND,   20'h00000, 13'd0,    1'b1, STAT_NOT_FOUND, 20'h0);
		foreach (plan[i])
			issue(plan[i].r, plan[i].typed, plan[i].want);

		// Fill the table to capacity, then try to append one more page. Try also an
		// update of a page that is already listed, which must still succeed.
		r.kind = KIND_UPDATE;
		for (int p = 0; p < ENTRIES_DEF; p++) begin
			r.page_number = 20'h80000 + PAGE_W'(p * 'h111);
			r.byte_count = BYTES_W'(p * 64);
			issue(r, 1'b0, none);
		end
		r.page_number = 20'h7FFFF;
		r.byte_count = 13'd1;
		issue(r, 1'b1, '{status: STAT_FULL, found_page: 20'h0});
		r.page_number = 20'h80000;
		r.byte_count = 13'd4096;
		issue(r, 1'b1, '{status: STAT_OK, found_page: 20'h0});
		r.kind = KIND_FIND;
		r.byte_count = 13'd4033;
		issue(r, 1'b0, none);

		while (counted < RANDOM_REQUESTS)
			random_episode(counted);

		// Drop start, let the outstanding answers drain, and allow a scan's worth of
		// extra cycles for any stray strobe.
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SCAN_CYCLES + 4) @(posedge clk);

		$display("covered %0d updates (%0d appends, %0d refused as full), %0d finds",
			n_update, n_append, n_full, n_find);
		$display("  (%0d hits, %0d misses), %0d clears, %0d ignored kinds; %0d answers checked",
			n_hit, n_miss, n_clear, n_idle_kind, answers_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Stop a hung run. A normal run takes well under a tenth of this.
	initial begin
		#400000;
		$display("timeout with %0d answers pending", pending_answers.size());
		$display("end of test: mismatches");
		$finish;
	end
endmodule
